>>> hdl/epr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epr_pkg;

	// Widths of the report payload
	localparam int DIST_W  = 10;
	localparam int BYTE_W  = 8;
	localparam int SCALE_W = 16;
	localparam int STEP_W  = 8;
	localparam int NBANDS  = 8;
	localparam int NBYTES  = 7;
	localparam int POS_W   = 3;
	localparam int BAND_W  = 3;

	// Configuration register indexes
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_BAND  = 1'b1;

	// Configuration reset values
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd21481;
	localparam logic [STEP_W-1:0]  STEP_RST  = 8'd25;

	// Distance ceiling
	localparam logic [DIST_W-1:0] DIST_MAX = 10'd999;

	// Fixed report bytes
	localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] UNIT_C      = 8'h63;
	localparam logic [BYTE_W-1:0] UNIT_M      = 8'h6D;
	localparam logic [BYTE_W-1:0] NOTE_LENGTH = 8'hD5;

	// Byte positions in the report buffer
	localparam logic [POS_W-1:0] POS_HUND  = 3'd0;
	localparam logic [POS_W-1:0] POS_TENS  = 3'd1;
	localparam logic [POS_W-1:0] POS_UNITS = 3'd2;
	localparam logic [POS_W-1:0] POS_NOTE  = 3'd5;
	localparam logic [POS_W-1:0] POS_TONE  = 3'd6;

	// Tone code for each distance band
	function automatic logic [BYTE_W-1:0] tone_code(input logic [BAND_W-1:0] band);
		logic [BYTE_W-1:0] code;
		unique case (band)
			3'd0: code = 8'hDC;
			3'd1: code = 8'hDE;
			3'd2: code = 8'hDF;
			3'd3: code = 8'hE1;
			3'd4: code = 8'hE3;
			3'd5: code = 8'hE4;
			3'd6: code = 8'hE6;
			default: code = 8'hE7;
		endcase
		return code;
	endfunction

	// LED bar pattern for each distance band
	function automatic logic [BYTE_W-1:0] led_code(input logic [BAND_W-1:0] band);
		logic [BYTE_W-1:0] code;
		unique case (band)
			3'd0: code = 8'hFF;
			3'd1: code = 8'hFE;
			3'd2: code = 8'hFE;
			3'd3: code = 8'hF8;
			3'd4: code = 8'hF0;
			3'd5: code = 8'hE0;
			3'd6: code = 8'hC0;
			default: code = 8'h80;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

>>> hdl/echo_pulse_range_reporter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Echo pulse ranging: one echo line sample is taken per clock on the input
// channel while in_stall is low. A falling edge of the echo starts a report
// that passes the count capture and distance stages into the report buffer and
// occupies 4 to 7 output transactions (digits without leading zeros, "cm", the
// note length byte and, for distances below eight bands, a tone code), one byte
// per cycle from the report buffer while out_stall is low. The input stalls
// only when the report buffer and both pipeline stages in front of it are
// occupied. Falling edges can come every second sample while a report needs at
// least four output transactions, so closely spaced pulses back the pipeline up
// even with no output stall, and a stalled output does so sooner. Distance is
// (count * scale_q16) >> 16, saturated at 999.
// Configure only while idle. COUNT_BITS sets the width of the pulse counter.
module echo_pulse_range_reporter_top
	import epr_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_wr_en,
	input  wire logic              cfg_index,
	input  wire logic [SCALE_W-1:0] cfg_wdata,
	// echo samples
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              echo_level,
	// report bytes
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic [DIST_W-1:0]      distance_cm,
	output logic [BYTE_W-1:0]      led_pattern,
	output logic                   last
);

	localparam int PROD_W = COUNT_BITS + SCALE_W;
	localparam int CMP_W  = COUNT_BITS + DIST_W;

	// Configuration and measurement state
	logic [SCALE_W-1:0]    scale_q;
	logic [STEP_W-1:0]     band_step_q;
	logic [COUNT_BITS-1:0] tick_count_q;
	logic                  echo_prev_q;
	logic [BYTE_W-1:0]     led_bar_q;

	// Stage 1: captured pulse count
	logic                  valid_s1;
	logic [COUNT_BITS-1:0] count_s1;

	// Stage 2: distance
	logic                  valid_s2;
	logic [DIST_W-1:0]     dist_s2;

	// Stage 3: report buffer
	logic                  valid_s3;
	logic [BYTE_W-1:0]     byte_s3 [NBYTES];
	logic [DIST_W-1:0]     dist_s3;
	logic [BYTE_W-1:0]     led_s3;
	logic [POS_W-1:0]      end_s3;
	logic [POS_W-1:0]      pos_q;

	// Flow control
	logic in_acc, out_acc, out_done;
	logic free_s1, free_s2, free_s3;
	logic falling;

	assign out_acc  = valid_s3 && !out_stall;
	assign out_done = out_acc && (pos_q == end_s3);
	assign free_s3  = !valid_s3 || out_done;
	assign free_s2  = !valid_s2 || free_s3;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_stall = !free_s1;
	assign in_acc   = in_valid && free_s1;
	assign falling  = in_acc && !echo_level && echo_prev_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			band_step_q <= STEP_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCALE: scale_q     <= cfg_wdata;
				REG_BAND:  band_step_q <= cfg_wdata[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Count ticks while the echo is high, clear after each falling edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			echo_prev_q  <= 1'b0;
		end else if (in_acc) begin
			echo_prev_q <= echo_level;
			if (echo_level) begin
				if (!echo_prev_q)
					tick_count_q <= COUNT_BITS'(1);
				else if (!(&tick_count_q))
					tick_count_q <= tick_count_q + COUNT_BITS'(1);
			end else if (echo_prev_q) begin
				tick_count_q <= '0;
			end
		end
	end

	// Stage 1: capture the count on a falling edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (free_s1)
			valid_s1 <= falling;
	end

	always_ff @(posedge clk) begin
		if (falling)
			count_s1 <= tick_count_q;
	end

	// Stage 2: scale to centimetres and saturate
	logic [PROD_W-1:0]  prod;
	logic [CMP_W-1:0]   whole_cm;
	logic [DIST_W-1:0]  dist_sat;

	always_comb begin
		prod     = PROD_W'(count_s1) * PROD_W'(scale_q);
		whole_cm = CMP_W'(prod[PROD_W-1:SCALE_W]);
		if (whole_cm > CMP_W'(DIST_MAX))
			dist_sat = DIST_MAX;
		else
			dist_sat = whole_cm[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (free_s2)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (free_s2 && valid_s1)
			dist_s2 <= dist_sat;
	end

	// Split the distance into decimal digits by reciprocal multiplication
	logic [15:0]       hund_prod;
	logic [3:0]        hund;
	logic [6:0]        rem_hund;
	logic [14:0]       tens_prod;
	logic [3:0]        tens;
	logic [3:0]        units;

	always_comb begin
		hund_prod = 16'(dist_s2) * 16'd41;
		hund      = hund_prod[15:12];
		rem_hund  = 7'(dist_s2 - DIST_W'(hund) * DIST_W'(100));
		tens_prod = 15'(rem_hund) * 15'd205;
		tens      = tens_prod[14:11];
		units     = 4'(rem_hund - 7'(tens) * 7'd10);
	end

	// Find the distance band against multiples of the band step
	logic [STEP_W-1:0]      step_eff;
	logic [NBANDS-1:0]      at_or_past;
	logic [BAND_W-1:0]      band;
	logic                   band_hit;

	always_comb begin
		step_eff = (band_step_q == '0) ? STEP_W'(1) : band_step_q;
		for (int k = 0; k < NBANDS; k++)
			at_or_past[k] = (11'(dist_s2) >= 11'(step_eff) * 11'(k + 1));
		band = '0;
		for (int k = 0; k < NBANDS - 1; k++)
			band = band + BAND_W'(at_or_past[k]);
		band_hit = !at_or_past[NBANDS-1];
	end

	// Stage 3: load the report buffer and walk through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3  <= 1'b0;
			pos_q     <= '0;
			led_bar_q <= '0;
		end else if (free_s3) begin
			valid_s3 <= valid_s2;
			if (valid_s2) begin
				if (dist_s2 >= DIST_W'(100))
					pos_q <= POS_HUND;
				else if (dist_s2 >= DIST_W'(10))
					pos_q <= POS_TENS;
				else
					pos_q <= POS_UNITS;
				if (band_hit)
					led_bar_q <= led_code(band);
			end
		end else if (out_acc) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			byte_s3[0] <= ASCII_ZERO + BYTE_W'(hund);
			byte_s3[1] <= ASCII_ZERO + BYTE_W'(tens);
			byte_s3[2] <= ASCII_ZERO + BYTE_W'(units);
			byte_s3[3] <= UNIT_C;
			byte_s3[4] <= UNIT_M;
			byte_s3[5] <= NOTE_LENGTH;
			byte_s3[6] <= tone_code(band);
			dist_s3    <= dist_s2;
			led_s3     <= band_hit ? led_code(band) : led_bar_q;
			end_s3     <= band_hit ? POS_TONE : POS_NOTE;
		end
	end

	// Drive the output transaction
	assign out_valid   = valid_s3;
	assign out_byte    = byte_s3[pos_q];
	assign distance_cm = dist_s3;
	assign led_pattern = led_s3;
	assign last        = (pos_q == end_s3);

endmodule

`default_nettype wire

>>> hdl/echo_pulse_range_reporter_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module echo_pulse_range_reporter_chk
	import epr_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [BYTE_W-1:0] out_byte,
	input wire logic [DIST_W-1:0] distance_cm,
	input wire logic [BYTE_W-1:0] led_pattern,
	input wire logic              last
);

	// Distance never exceeds the ceiling
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_cm <= DIST_MAX)
		else $error("distance above ceiling");

	// A report continues without a gap and keeps its distance
	a_report_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
			out_valid && distance_cm == $past(distance_cm))
		else $error("report broken or distance changed mid-report");

	// The LED pattern holds across one report
	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> led_pattern == $past(led_pattern))
		else $error("LED pattern changed mid-report");

	// A report ends with the note length byte or a tone code
	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_byte >= NOTE_LENGTH)
		else $error("report ends on a digit or unit byte");

	// A stalled transaction holds its byte
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte))
		else $error("stalled byte changed");

endmodule

bind echo_pulse_range_reporter_top echo_pulse_range_reporter_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.distance_cm (distance_cm),
	.led_pattern (led_pattern),
	.last        (last)
);

`default_nettype wire

>>> verif/echo_pulse_range_reporter_top_tb.sv
`timescale 1ns / 1ps

module echo_pulse_range_reporter_top_tb;
	import epr_pkg::*;

	localparam int CNT_W        = 16;
	localparam int MAX_IDLE     = 4;
	localparam int SETTLE       = 8;
	localparam int WDOG_MAX     = 2000;
	localparam int RAND_SAMPLES = 220;
	localparam int RAND_PULSES  = 48;
	localparam int PREDICT      = -1;
	localparam int DIR_ROWS     = 25;

	// Tone codes and LED patterns per band, band 0 in the low byte
	localparam logic [NBANDS*BYTE_W-1:0] TONE_TBL =
		{8'hE7, 8'hE6, 8'hE4, 8'hE3, 8'hE1, 8'hDF, 8'hDE, 8'hDC};
	localparam logic [NBANDS*BYTE_W-1:0] LED_TBL =
		{8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFE, 8'hFE, 8'hFF};

	typedef struct packed {
		logic [BYTE_W-1:0] code;
		logic [DIST_W-1:0] cm;
		logic [BYTE_W-1:0] led;
		logic              fin;
	} report_byte_t;

	// One directed pulse: register setting, high ticks, low ticks after it and
	// the distance it must give (PREDICT leaves it to the range predictor)
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [STEP_W-1:0]  step;
		int                 width;
		int                 gap;
		int                 cm;
	} pulse_row_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               cfg_wr_en  = 1'b0;
	logic               cfg_index  = REG_SCALE;
	logic [SCALE_W-1:0] cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               echo_level = 1'b0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic [DIST_W-1:0]  distance_cm;
	logic [BYTE_W-1:0]  led_pattern;
	logic               last;

	// Range predictor state and its copy of the registers
	logic [CNT_W-1:0]   tick_cnt      = '0;
	logic               echo_was_high = 1'b0;
	logic [BYTE_W-1:0]  led_bar_q     = '0;
	logic [SCALE_W-1:0] cur_scale     = SCALE_RST;
	logic [STEP_W-1:0]  cur_step      = STEP_RST;

	report_byte_t report_bytes_q[$];
	report_byte_t want;
	pulse_row_t   pulse_tbl [DIR_ROWS];

	int sample_cm_hint = PREDICT;
	int idle_cycles    = 0;
	int fail_cnt       = 0;
	int samples_sent   = 0;
	int reports_queued = 0;
	int bytes_seen     = 0;
	int settings_used  = 1;
	bit calm           = 1'b0;
	bit moved;

	echo_pulse_range_reporter_top #(
		.COUNT_BITS(CNT_W)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.echo_level (echo_level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.distance_cm(distance_cm),
		.led_pattern(led_pattern),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Build the byte sequence of one report and queue it
	function automatic void queue_report(input int cm);
		logic [BYTE_W-1:0] msg [NBYTES];
		int                n;
		int                band;
		int                step_eff;
		report_byte_t      rb;
		n = 0;
		if (cm >= 100) begin
			msg[n] = ASCII_ZERO + BYTE_W'(cm / 100);
			n++;
		end
		if (cm >= 10) begin
			msg[n] = ASCII_ZERO + BYTE_W'((cm / 10) % 10);
			n++;
		end
		msg[n] = ASCII_ZERO + BYTE_W'(cm % 10);
		msg[n + 1] = UNIT_C;
		msg[n + 2] = UNIT_M;
		msg[n + 3] = NOTE_LENGTH;
		n = n + 4;
		// treat a zero band step as one centimetre
		step_eff = (cur_step == '0) ? 1 : int'(cur_step);
		band = cm / step_eff;
		if (band < NBANDS) begin
			msg[n] = TONE_TBL[band*BYTE_W +: BYTE_W];
			led_bar_q = LED_TBL[band*BYTE_W +: BYTE_W];
			n++;
		end
		for (int k = 0; k < n; k++) begin
			rb.code = msg[k];
			rb.cm   = DIST_W'(cm);
			rb.led  = led_bar_q;
			rb.fin  = (k == n - 1);
			report_bytes_q.push_back(rb);
		end
		reports_queued++;
	endfunction

	// Advance the pulse counter by one echo sample; report on a falling edge
	function automatic void predict_sample(input logic level, input int cm_hint);
		logic [47:0] prod;
		int          cm;
		if (level) begin
			if (!echo_was_high)
				tick_cnt = CNT_W'(1);
			else if (tick_cnt != {CNT_W{1'b1}})
				tick_cnt = tick_cnt + 1'b1;
			echo_was_high = 1'b1;
		end else if (echo_was_high) begin
			echo_was_high = 1'b0;
			prod = tick_cnt * cur_scale;
			prod = prod >> 16;
			cm = (prod > DIST_MAX) ? int'(DIST_MAX) : int'(prod);
			if (cm_hint != PREDICT)
				cm = cm_hint;
			tick_cnt = '0;
			queue_report(cm);
		end
	endfunction

	// Check each output transaction, then predict from each input transaction
	always @(posedge clk) begin
		moved = 1'b0;
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			bytes_seen++;
			if (report_bytes_q.size() == 0) begin
				$error("report byte %h with nothing expected", out_byte);
				fail_cnt++;
			end else begin
				want = report_bytes_q.pop_front();
				if (out_byte !== want.code) begin
					$error("out_byte: expected %h, got %h", want.code, out_byte);
					fail_cnt++;
				end
				if (distance_cm !== want.cm) begin
					$error("distance_cm: expected %0d, got %0d", want.cm, distance_cm);
					fail_cnt++;
				end
				if (led_pattern !== want.led) begin
					$error("led_pattern: expected %h, got %h", want.led, led_pattern);
					fail_cnt++;
				end
				if (last !== want.fin) begin
					$error("last: expected %b, got %b", want.fin, last);
					fail_cnt++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			moved = 1'b1;
			predict_sample(echo_level, sample_cm_hint);
		end
		if (arst_n)
			idle_cycles <= moved ? 0 : idle_cycles + 1;
	end

	// End the run when no transaction has moved for too long
	initial begin : watchdog
		wait (arst_n);
		while (idle_cycles < WDOG_MAX)
			@(posedge clk);
		$error("no transaction for %0d cycles", WDOG_MAX);
		$display("echo_pulse_range_reporter_top: mismatch");
		$finish;
	end

	// Stall the output side for a random number of cycles per byte
	initial begin : out_side
		int hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_IDLE);
			if (hold > 0) begin
				@(negedge clk) out_stall <= 1'b1;
				repeat (hold - 1) @(negedge clk);
				@(negedge clk) out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Drive one echo sample after a random gap and hold it until accepted
	task automatic send_sample(input logic level, input int cm_hint);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			@(negedge clk) in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		echo_level     <= level;
		sample_cm_hint <= cm_hint;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// Drive a high pulse followed by low ticks; the first low tick ends it
	task automatic send_pulse(input int width, input int gap, input int cm);
		repeat (width) send_sample(1'b1, PREDICT);
		if (gap > 0) begin
			send_sample(1'b0, cm);
			repeat (gap - 1) send_sample(1'b0, PREDICT);
		end
	endtask

	// Drain all reports, let the pipeline settle, then write both registers
	task automatic set_config(input logic [SCALE_W-1:0] scale, input logic [STEP_W-1:0] step);
		logic [7:0] pad;
		pad = 8'($urandom_range(0, 255));
		@(negedge clk) in_valid <= 1'b0;
		while (report_bytes_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_wdata <= scale;
		cur_scale = scale;
		@(negedge clk);
		cfg_index <= REG_BAND;
		cfg_wdata <= {pad, step};
		cur_step = step;
		@(negedge clk) cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin : stim
		int                 pick;
		int                 w;
		int                 pulses;
		int                 since_cfg;
		logic [SCALE_W-1:0] scale;
		logic [STEP_W-1:0]  step;

		// With full scale a pulse of w ticks reads w - 1 cm
		pulse_tbl = '{
			'{SCALE_RST, STEP_RST, 0,     3, PREDICT}, // low ticks only
			'{SCALE_RST, STEP_RST, 40,    1, PREDICT},
			'{SCALE_RST, STEP_RST, 3053,  2, PREDICT}, // past the ceiling
			'{16'hFFFF,  8'd25,    1,     1, 0},       // zero distance
			'{16'hFFFF,  8'd25,    2,     2, 1},
			'{16'hFFFF,  8'd25,    10,    1, 9},
			'{16'hFFFF,  8'd25,    11,    3, 10},
			'{16'hFFFF,  8'd25,    25,    1, 24},
			'{16'hFFFF,  8'd25,    26,    2, 25},
			'{16'hFFFF,  8'd25,    100,   1, 99},
			'{16'hFFFF,  8'd25,    101,   1, 100},
			'{16'hFFFF,  8'd25,    200,   2, 199},     // top band
			'{16'hFFFF,  8'd25,    201,   1, 200},     // beyond the bands
			'{16'hFFFF,  8'd25,    1000,  1, 999},
			'{16'hFFFF,  8'd25,    1200,  2, 999},     // saturated
			'{16'd0,     8'd1,     50,    2, 0},
			'{16'hFFFF,  8'd1,     8,     1, 7},
			'{16'hFFFF,  8'd1,     9,     2, 8},
			'{16'hFFFF,  8'd255,   1000,  1, 999},
			'{16'hFFFF,  8'd255,   256,   2, 255},
			'{16'hFFFF,  8'd0,     9,     1, 8},       // zero step acts as one
			'{16'hFFFF,  8'd0,     8,     2, 7},
			'{16'd16,    8'd25,    65535, 2, 15},
			'{16'd16,    8'd25,    65540, 2, 15},      // counter holds at its top
			'{SCALE_RST, STEP_RST, 61,    3, PREDICT}
		};

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Walk the directed table, rewriting registers where a row asks
		for (int k = 0; k < DIR_ROWS; k++) begin
			if (pulse_tbl[k].scale != cur_scale || pulse_tbl[k].step != cur_step)
				set_config(pulse_tbl[k].scale, pulse_tbl[k].step);
			send_pulse(pulse_tbl[k].width, pulse_tbl[k].gap, pulse_tbl[k].cm);
		end

		// Random pulses with occasional noise and a new setting every few reports
		pulses = 0;
		since_cfg = 8;
		while (samples_sent < RAND_SAMPLES || pulses < RAND_PULSES) begin
			if (since_cfg == 8) begin
				send_sample(1'b0, PREDICT);
				pick = $urandom_range(0, 9);
				scale = (pick == 0) ? 16'd0 :
					(pick < 4) ? 16'hFFFF : 16'($urandom_range(1, 65534));
				pick = $urandom_range(0, 9);
				step = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 :
					(pick == 2) ? 8'd255 : 8'($urandom_range(2, 60));
				set_config(scale, step);
				calm = ($urandom_range(0, 3) == 0);
				since_cfg = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)), PREDICT);
			end else begin
				w = (pick < 80) ? $urandom_range(1, 24) :
					(pick < 95) ? $urandom_range(25, 260) : $urandom_range(261, 1100);
				send_pulse(w, $urandom_range(1, 4), PREDICT);
				pulses++;
				since_cfg++;
			end
		end

		// Drain outstanding reports and give the pipeline time to go quiet
		@(negedge clk) in_valid <= 1'b0;
		while (report_bytes_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		$display("run covered %0d echo samples, %0d range reports and %0d report bytes",
			samples_sent, reports_queued, bytes_seen);
		$display("over %0d register settings, %0d checks failed", settings_used, fail_cnt);
		if (fail_cnt == 0)
			$display("echo_pulse_range_reporter_top: match");
		else
			$display("echo_pulse_range_reporter_top: mismatch");
		$finish;
	end

endmodule
